[hw/rtl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; every other file of the block imports this package.
package u8d_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned CntWidth = 3;   // up to four results for one byte

  localparam logic [CpWidth-1:0] QMark = CpWidth'(63);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } u8d_in_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               run_last;
    logic               string_last;
  } u8d_out_t;

  // Results of one byte: (cnt - 1) question marks, then last_cp.
  typedef struct packed {
    logic [CntWidth-1:0] cnt;
    logic [CpWidth-1:0]  last_cp;
    logic                fin;
  } u8d_run_t;

  typedef struct packed {
    logic [1:0] bytes_needed;
    logic [1:0] bytes_seen;
  } u8d_stat_t;

endpackage

[hw/rtl/u8d_decode.sv]
// Sequence state registers and combinational byte decode.
// Depends on u8d_pkg; feeds a result run to u8d_emit.
module u8d_decode import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  u8d_in_t   in_data_i,
  input  logic      in_fire_i,
  output u8d_run_t  run_o,
  output u8d_stat_t stat_o
);

  logic [CpWidth-1:0] partial_q, partial_d;
  logic [1:0]         needed_q, needed_d;
  logic [1:0]         seen_q, seen_d;

  logic [7:0]         b;
  logic               fin;
  logic               cont;
  logic               fresh;
  logic [1:0]         qcnt;
  logic               extra;
  logic [CpWidth-1:0] joined;
  logic [1:0]         nn;
  logic [1:0]         ns;

  always_comb begin
    b      = in_data_i.byte_value;
    fin    = in_data_i.final_byte;
    cont   = (b[7:6] == 2'b10);
    joined = {partial_q[CpWidth-7:0], b[5:0]};
    nn     = needed_q - 2'd1;
    ns     = seen_q + 2'd1;

    partial_d     = partial_q;
    needed_d      = needed_q;
    seen_d        = seen_q;
    fresh         = 1'b1;
    qcnt          = 2'd0;
    extra         = 1'b0;
    run_o.last_cp = QMark;

    if (needed_q != 2'd0) begin
      if (cont) begin
        fresh = 1'b0;
        if (nn == 2'd0) begin
          extra         = 1'b1;
          run_o.last_cp = joined;
          partial_d     = '0;
          needed_d      = 2'd0;
          seen_d        = 2'd0;
        end else if (fin) begin
          // early end: one mark per buffered byte, this one included
          qcnt      = ns;
          partial_d = '0;
          needed_d  = 2'd0;
          seen_d    = 2'd0;
        end else begin
          partial_d = joined;
          needed_d  = nn;
          seen_d    = ns;
        end
      end else begin
        // broken sequence: flush, then decode this byte afresh
        qcnt      = seen_q;
        partial_d = '0;
        needed_d  = 2'd0;
        seen_d    = 2'd0;
      end
    end

    if (fresh) begin
      if (b[7] == 1'b0) begin
        extra         = 1'b1;
        run_o.last_cp = CpWidth'(b);
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        if (fin) begin
          // lead byte that ends the string
          extra     = 1'b1;
          partial_d = '0;
          needed_d  = 2'd0;
          seen_d    = 2'd0;
        end else begin
          seen_d = 2'd1;
          if (b[7:5] == 3'b110) begin
            partial_d = CpWidth'(b[4:0]);
            needed_d  = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            partial_d = CpWidth'(b[3:0]);
            needed_d  = 2'd2;
          end else begin
            partial_d = CpWidth'(b[2:0]);
            needed_d  = 2'd3;
          end
        end
      end else begin
        extra = 1'b1;
      end
    end

    run_o.cnt = CntWidth'(qcnt) + CntWidth'(extra);
    run_o.fin = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      needed_q  <= 2'd0;
      seen_q    <= 2'd0;
    end else if (in_fire_i) begin
      partial_q <= partial_d;
      needed_q  <= needed_d;
      seen_q    <= seen_d;
    end
  end

  assign stat_o.bytes_needed = needed_q;
  assign stat_o.bytes_seen   = seen_q;

endmodule

[hw/rtl/u8d_emit.sv]
// Result register: holds a byte's run, plays it out one item a cycle while ready.
// Depends on u8d_pkg; loaded by u8d_decode through the top level.
module u8d_emit import u8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  u8d_run_t run_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output u8d_out_t out_data_o,
  output logic     load_ready_o
);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [CpWidth-1:0]  last_q;
  logic                fin_q;
  logic                is_last;
  logic                out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign is_last     = (cnt_q == CntWidth'(1));
  assign out_fire    = out_valid_o && out_ready_i;

  // take a new run when empty or when the final item leaves this cycle
  assign load_ready_o = (cnt_q == '0) || (is_last && out_ready_i);

  assign out_data_o.code_point  = is_last ? last_q : QMark;
  assign out_data_o.run_last    = is_last;
  assign out_data_o.string_last = is_last && fin_q;

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire_i) begin
      cnt_d = run_i.cnt;
    end else if (out_fire) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      last_q <= run_i.last_cp;
      fin_q  <= run_i.fin;
    end
  end

endmodule

[hw/rtl/utf8_codepoint_decoder_unit.sv]
// Top level of the UTF-8 code point decoder: byte decode plus result register.
// Depends on u8d_pkg, u8d_decode and u8d_emit.
//
//   channel   signals                          payload
//   input     in_valid_i / in_ready_o          in_data_i  (u8d_in_t)
//   output    out_valid_o / out_ready_i        out_data_o (u8d_out_t)
//
// One byte is taken per cycle while in_ready_o is high; its results appear
// from the next cycle on, one per cycle while out_ready_i is high. A byte
// giving k results (0 to 4) holds the input while more than one is left in
// the result register; with one left, input ready follows out_ready_i
// combinationally. Reset clears the sequence state and the result register.
module utf8_codepoint_decoder_unit import u8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  u8d_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output u8d_out_t out_data_o
);

  logic      in_fire;
  u8d_run_t  run;
  u8d_stat_t stat;

  assign in_fire = in_valid_i && in_ready_o;

  u8d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .in_fire_i (in_fire),
    .run_o     (run),
    .stat_o    (stat)
  );

  u8d_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .run_i        (run),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .load_ready_o (in_ready_o)
  );

  // a final byte always yields at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.final_byte |=> out_valid_o)
    else $error("final byte produced no result");

  // the string state is cleared after a final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.final_byte |=> stat.bytes_needed == 2'd0 && stat.bytes_seen == 2'd0)
    else $error("sequence state left open after final byte");

  // all but the last result of a run are question marks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |-> out_data_o.code_point == QMark)
    else $error("non-final run item is not a question mark");

  // a result that is not the last of its run is followed by more
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.run_last |=> out_valid_o)
    else $error("run ended early");

endmodule

[tb/testbench.sv]
// Self-checking bench for utf8_codepoint_decoder_unit: a directed byte table, then random strings.
// Accepted bytes feed a local decoder model; typed or modelled code points are checked in order.
// Depends on u8d_pkg and the decoder RTL.
module testbench;
  import u8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandItems = 440;
  localparam int IdleLimit = 4000;
  localparam int MaxShown  = 10;

  typedef struct packed {
    u8d_in_t                  d;
    logic                     chk;   // code points below are typed in, not predicted
    logic [2:0]               n;
    logic [3:0][CpWidth-1:0]  cp;
  } byte_item_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  u8d_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  u8d_out_t out_data_o;

  utf8_codepoint_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  byte_item_t          byte_q[$];
  u8d_out_t            cp_expected_q[$];
  logic [CpWidth-1:0]  run_cp_q[$];
  int                  n_directed;
  int                  pause_a;
  int                  pause_b;
  int                  n_errors   = 0;
  logic                drive_done = 1'b0;

  // Decoder model state
  logic [CpWidth-1:0] acc_bits = '0;
  logic [1:0]         need_cnt = '0;
  logic [1:0]         seen_cnt = '0;

  function automatic void clear_seq();
    acc_bits = '0;
    need_cnt = '0;
    seen_cnt = '0;
  endfunction

  function automatic void flush_seq();
    for (int i = 0; i < int'(seen_cnt); i++) run_cp_q = {run_cp_q, QMark};
    clear_seq();
  endfunction

  // Fill run_cp_q with the code points one byte produces.
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic fresh;
    fresh = 1'b1;
    run_cp_q.delete();
    if (need_cnt != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh    = 1'b0;
        acc_bits = {acc_bits[CpWidth-7:0], b[5:0]};
        seen_cnt = seen_cnt + 2'd1;
        need_cnt = need_cnt - 2'd1;
        if (need_cnt == 2'd0) begin
          run_cp_q = {run_cp_q, acc_bits};
          clear_seq();
        end else if (fin) begin
          flush_seq();
        end
      end else begin
        flush_seq();
      end
    end
    if (fresh) begin
      if (!b[7]) begin
        run_cp_q = {run_cp_q, CpWidth'(b)};
      end else if (b[7:5] == 3'b110) begin
        acc_bits = CpWidth'(b[4:0]);
        need_cnt = 2'd1;
        seen_cnt = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_bits = CpWidth'(b[3:0]);
        need_cnt = 2'd2;
        seen_cnt = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        acc_bits = CpWidth'(b[2:0]);
        need_cnt = 2'd3;
        seen_cnt = 2'd1;
      end else begin
        run_cp_q = {run_cp_q, QMark};
      end
      if (fin && need_cnt != 2'd0) flush_seq();
    end
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      2:       lead_byte = {3'b110, 5'($urandom_range(0, 31))};
      3:       lead_byte = {4'b1110, 4'($urandom_range(0, 15))};
      default: lead_byte = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    cont_byte = {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // n < 0: results come from the model; otherwise c0..c3 are the typed code points.
  task automatic queue_byte(input logic [7:0] b, input logic fin, input int n,
                            input logic [CpWidth-1:0] c0, input logic [CpWidth-1:0] c1,
                            input logic [CpWidth-1:0] c2, input logic [CpWidth-1:0] c3);
    byte_item_t s;
    s              = '0;
    s.d.byte_value = b;
    s.d.final_byte = fin;
    s.chk          = (n >= 0);
    s.n            = (n >= 0) ? 3'(n) : 3'd0;
    s.cp[0]        = c0;
    s.cp[1]        = c1;
    s.cp[2]        = c2;
    s.cp[3]        = c3;
    byte_q = {byte_q, s};
  endtask

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= MaxShown) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Stimulus, reset and end of run
  initial begin : run_ctrl
    logic [7:0] str_q[$];
    int n_cp;
    int kind;
    int len;
    int n_cont;
    // ASCII extremes, stray bytes, invalid leads
    queue_byte(8'h00, 1'b0, 1, 21'h00, 0, 0, 0);
    queue_byte(8'h7F, 1'b0, 1, 21'h7F, 0, 0, 0);
    queue_byte(8'h80, 1'b0, 1, QMark, 0, 0, 0);
    queue_byte(8'hF8, 1'b0, 1, QMark, 0, 0, 0);
    queue_byte(8'hFF, 1'b0, 1, QMark, 0, 0, 0);
    // overlong two-byte zero, then the largest two-byte form
    queue_byte(8'hC0, 1'b0, 0, 0, 0, 0, 0);
    queue_byte(8'h80, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'hDF, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'hBF, 1'b0, -1, 0, 0, 0, 0);
    // surrogate passes through
    queue_byte(8'hED, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'hA0, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'h80, 1'b0, -1, 0, 0, 0, 0);
    // largest four-byte value
    queue_byte(8'hF7, 1'b0, 0, 0, 0, 0, 0);
    queue_byte(8'hBF, 1'b0, 0, 0, 0, 0, 0);
    queue_byte(8'hBF, 1'b0, 0, 0, 0, 0, 0);
    queue_byte(8'hBF, 1'b0, 1, 21'h1FFFFF, 0, 0, 0);
    // sequence broken by ASCII
    queue_byte(8'hF0, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'h90, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'h41, 1'b0, -1, 0, 0, 0, 0);
    // string ends inside a sequence
    queue_byte(8'hE1, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'h80, 1'b1, 2, QMark, QMark, 0, 0);
    // lead byte as the final byte
    queue_byte(8'hC3, 1'b1, 1, QMark, 0, 0, 0);
    // final lead byte breaks a three-byte buffer: four results
    queue_byte(8'hF0, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'h90, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'h90, 1'b0, -1, 0, 0, 0, 0);
    queue_byte(8'hC2, 1'b1, 4, QMark, QMark, QMark, QMark);
    queue_byte(8'h41, 1'b1, 1, 21'h41, 0, 0, 0);
    n_directed = byte_q.size();
    pause_a    = n_directed;
    pause_b    = n_directed + RandItems / 2;

    // Random strings: mostly well formed, some stray, invalid and truncated bytes
    while (byte_q.size() < n_directed + RandItems) begin
      str_q.delete();
      n_cp = $urandom_range(1, 10);
      for (int c = 0; c < n_cp; c++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          str_q = {str_q, 8'($urandom_range(0, 127))};
        end else if (kind < 80) begin
          len = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
          str_q = {str_q, lead_byte(len)};
          for (int j = 1; j < len; j++) str_q = {str_q, cont_byte()};
        end else if (kind < 86) begin
          str_q = {str_q, cont_byte()};
        end else if (kind < 90) begin
          str_q = {str_q, 8'($urandom_range(248, 255))};
        end else begin
          len    = $urandom_range(2, 4);
          n_cont = $urandom_range(0, len - 2);
          str_q = {str_q, lead_byte(len)};
          for (int j = 0; j < n_cont; j++) str_q = {str_q, cont_byte()};
        end
      end
      foreach (str_q[j]) queue_byte(str_q[j], j == str_q.size() - 1, -1, 0, 0, 0, 0);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(drive_done && cp_expected_q.size() == 0)) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Byte sender: bursts and gaps, two drain pauses
  initial begin : send_bytes
    int         k;
    int         burst_left;
    int         gap_left;
    byte_item_t s;
    u8d_out_t   e;
    k          = 0;
    burst_left = 0;
    gap_left   = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    while (k < byte_q.size()) begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) begin
        s = byte_q[k];
        decode_byte(s.d.byte_value, s.d.final_byte);
        if (s.chk) begin
          run_cp_q.delete();
          for (int i = 0; i < int'(s.n); i++) run_cp_q = {run_cp_q, s.cp[i]};
        end
        foreach (run_cp_q[i]) begin
          e.code_point  = run_cp_q[i];
          e.run_last    = (i == run_cp_q.size() - 1);
          e.string_last = e.run_last && s.d.final_byte;
          cp_expected_q = {cp_expected_q, e};
        end
        k++;
      end
      // hold an offered byte until it is taken
      if (in_valid_i && !in_ready_o) continue;
      if (k >= byte_q.size()) begin
        in_valid_i <= 1'b0;
      end else if ((k == pause_a || k == pause_b) && cp_expected_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= byte_q[k].d;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    drive_done = 1'b1;
  end

  // Result receiver: changing stall patterns, two long hold-offs
  initial begin : take_results
    int         mode;
    int         mode_left;
    int         n_taken;
    int         hold_left;
    logic [7:0] patt;
    mode      = 0;
    mode_left = 0;
    n_taken   = 0;
    hold_left = 0;
    patt      = 8'hFF;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_taken++;
        if (n_taken == 60 || n_taken == 180) hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
        patt      = 8'($urandom_range(1, 255));
      end
      mode_left--;
      patt = {patt[6:0], patt[7]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= patt[0];
        endcase
      end
    end
  end

  // Compare each taken result with the oldest expected code point
  initial begin : check_results
    u8d_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (cp_expected_q.size() == 0) begin
          note_error($sformatf("unexpected result cp=%06h run_last=%0b string_last=%0b",
                               out_data_o.code_point, out_data_o.run_last,
                               out_data_o.string_last));
        end else begin
          want = cp_expected_q.pop_front();
          if (out_data_o.code_point !== want.code_point ||
              out_data_o.run_last !== want.run_last ||
              out_data_o.string_last !== want.string_last) begin
            note_error($sformatf("expected cp=%06h rl=%0b sl=%0b, got cp=%06h rl=%0b sl=%0b",
                                 want.code_point, want.run_last, want.string_last,
                                 out_data_o.code_point, out_data_o.run_last,
                                 out_data_o.string_last));
          end
        end
      end
    end
  end

  // End the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("status: fail");
    $finish;
  end

endmodule
